@@ hdl/max_flow_bfs_augment_defines.svh @@
// assertion macros for the max flow block
// used by the top level; no other dependencies
`ifndef MAX_FLOW_BFS_AUGMENT_DEFINES_SVH
`define MAX_FLOW_BFS_AUGMENT_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define MFBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define MFBA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFBA_ASSERT(lbl, prop, msg)
`define MFBA_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/mfba_pkg.sv @@
// shared types and constants of the max flow block
// no dependencies
`default_nettype none

package mfba_pkg;

    localparam int CAP_W     = 16;
    localparam int RES_W     = 18;
    localparam int FLOW_W    = 20;
    localparam int OUT_W     = 19;
    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 2'd1;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MIN
    } alu_op_t;

endpackage

`default_nettype wire

@@ hdl/mfba_alu.sv @@
// shared add, subtract and minimum unit
// depends on mfba_pkg
`default_nettype none

module mfba_alu (
    input  mfba_pkg::alu_op_t             op,
    input  logic [mfba_pkg::FLOW_W-1:0]   a,
    input  logic [mfba_pkg::FLOW_W-1:0]   b,
    output logic [mfba_pkg::FLOW_W-1:0]   y
);
    import mfba_pkg::*;

    // one operation per cycle, chosen by the sequencer
    always_comb
    begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            ALU_MIN: y = (a < b) ? a : b;
            default: y = a;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/mfba_res_mem.sv @@
// residual capacity memory, one write and one registered read per cycle
// depends on mfba_pkg
`default_nettype none

module mfba_res_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [mfba_pkg::RES_W-1:0]   wdata,
    input  logic [ADDR_W-1:0]            raddr,
    output logic [mfba_pkg::RES_W-1:0]   rdata
);
    import mfba_pkg::*;

    logic [RES_W-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/max_flow_bfs_augment.sv @@
// channel  | direction | payload
// in       | request   | capacity, last_entry
// out      | result    | total_flow
// cfg      | write     | cfg_index, cfg_data
//
// loading takes one matrix entry per cycle; the request marked last (or the one
// that fills the matrix) starts the computation, during which in_ready is low
// the entries not loaded are zeroed first, one per cycle through the
// residual memory write port
// each search round reads the residual row of every dequeued vertex, then traces
// the path for its bottleneck and updates each hop, trace and update through one alu
// the result waits in an output register; loading goes on while it is pending
// the residual memory needs no clearing after reset or after a result
`default_nettype none

module max_flow_bfs_augment #(
    parameter int NODE_COUNT = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [mfba_pkg::CAP_W-1:0]       capacity,
    input  logic                             last_entry,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mfba_pkg::OUT_W-1:0]       total_flow,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mfba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfba_pkg::CFG_W-1:0]       cfg_data
);
    import mfba_pkg::*;

    `include "max_flow_bfs_augment_defines.svh"

    localparam int CELLS  = NODE_COUNT * NODE_COUNT;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int POS_W  = $clog2(CELLS + 1);
    localparam int NODE_W = $clog2(NODE_COUNT);
    localparam int CNT_W  = $clog2(NODE_COUNT + 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FILL,
        ST_START,
        ST_BFS_INIT,
        ST_BFS_POP,
        ST_BFS_FROM,
        ST_BFS_RD,
        ST_BFS_CHK,
        ST_TR_PAR,
        ST_TR_PWAIT,
        ST_TR_CMP,
        ST_UP_PAR,
        ST_UP_PWAIT,
        ST_UP_WF,
        ST_UP_WR,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [POS_W-1:0]        load_pos_reg, load_pos_next;
    logic [POS_W-1:0]        fill_reg, fill_next;
    logic [FLOW_W-1:0]       flow_reg, flow_next;
    logic [RES_W-1:0]        bott_reg, bott_next;
    logic [NODE_W-1:0]       from_reg, from_next;
    logic [NODE_W-1:0]       to_reg, to_next;
    logic [NODE_W-1:0]       node_reg, node_next;
    logic [NODE_W-1:0]       prev_reg, prev_next;
    logic [CNT_W-1:0]        steps_reg, steps_next;
    logic [CNT_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        tail_reg, tail_next;
    logic [NODE_COUNT-1:0]   seen_reg, seen_next;
    logic [CFG_W-1:0]        source_reg, source_next;
    logic [CFG_W-1:0]        sink_reg, sink_next;
    logic                    out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]        total_reg, total_next;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [RES_W-1:0]        mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;
    logic [RES_W-1:0]        mem_rdata;

    logic                    par_we;
    logic [NODE_W-1:0]       par_waddr;
    logic [NODE_W-1:0]       par_wdata;
    logic [NODE_W-1:0]       par_rdata;
    logic [NODE_W-1:0]       parent_mem [NODE_COUNT];

    logic                    q_we;
    logic [NODE_W-1:0]       q_waddr;
    logic [NODE_W-1:0]       q_wdata;
    logic [NODE_W-1:0]       q_rdata;
    logic [NODE_W-1:0]       queue_mem [NODE_COUNT];

    alu_op_t                 alu_op;
    logic [FLOW_W-1:0]       alu_a;
    logic [FLOW_W-1:0]       alu_b;
    logic [FLOW_W-1:0]       alu_y;

    logic [NODE_W-1:0]       src_node;
    logic [NODE_W-1:0]       dst_node;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [NODE_W-1:0] row,
                                                    input logic [NODE_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * NODE_COUNT + int'(col));
    endfunction

    assign src_node   = NODE_W'(source_reg);
    assign dst_node   = NODE_W'(sink_reg);
    assign in_ready   = (state_reg == ST_LOAD);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign total_flow = total_reg;

    mfba_res_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_res_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr  (mem_raddr),
        .rdata  (mem_rdata)
    );

    mfba_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // parent and queue stores, read addresses follow node and head
    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_waddr] <= par_wdata;
        end
        if (q_we)
        begin
            queue_mem[q_waddr] <= q_wdata;
        end
        par_rdata <= parent_mem[node_reg];
        q_rdata   <= queue_mem[head_reg[NODE_W-1:0]];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        load_pos_next  = load_pos_reg;
        fill_next      = fill_reg;
        flow_next      = flow_reg;
        bott_next      = bott_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        node_next      = node_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        seen_next      = seen_reg;
        source_next    = source_reg;
        sink_next      = sink_reg;
        out_valid_next = out_valid_reg;
        total_next     = total_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_raddr      = '0;
        par_we         = 1'b0;
        par_waddr      = '0;
        par_wdata      = '0;
        q_we           = 1'b0;
        q_waddr        = '0;
        q_wdata        = '0;
        alu_op         = ALU_ADD;
        alu_a          = '0;
        alu_b          = '0;

        // register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SOURCE: source_next = cfg_data;
                CFG_SINK:   sink_next   = cfg_data;
                default:    ;
            endcase
        end

        // result taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    mem_we        = 1'b1;
                    mem_waddr     = load_pos_reg[ADDR_W-1:0];
                    mem_wdata     = RES_W'(capacity);
                    load_pos_next = load_pos_reg + 1'b1;
                    if (last_entry || load_pos_reg == POS_W'(CELLS - 1))
                    begin
                        fill_next  = load_pos_reg + 1'b1;
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                // zero the entries that were not loaded
                if (fill_reg < POS_W'(CELLS))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = fill_reg[ADDR_W-1:0];
                    mem_wdata = '0;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                flow_next = '0;
                if (int'(source_reg) >= NODE_COUNT || int'(sink_reg) >= NODE_COUNT
                    || source_reg == sink_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_BFS_INIT;
                end
            end
            ST_BFS_INIT:
            begin
                seen_next           = '0;
                seen_next[src_node] = 1'b1;
                par_we              = 1'b1;
                par_waddr           = src_node;
                par_wdata           = src_node;
                q_we                = 1'b1;
                q_waddr             = '0;
                q_wdata             = src_node;
                head_next           = '0;
                tail_next           = CNT_W'(1);
                state_next          = ST_BFS_POP;
            end
            ST_BFS_POP:
            begin
                if (head_reg < tail_reg)
                begin
                    head_next  = head_reg + 1'b1;
                    state_next = ST_BFS_FROM;
                end
                else if (seen_reg[dst_node])
                begin
                    node_next  = dst_node;
                    steps_next = '0;
                    bott_next  = '1;
                    state_next = ST_TR_PAR;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BFS_FROM:
            begin
                from_next  = q_rdata;
                to_next    = '0;
                state_next = ST_BFS_RD;
            end
            ST_BFS_RD:
            begin
                mem_raddr  = cell_addr(from_reg, to_reg);
                state_next = ST_BFS_CHK;
            end
            ST_BFS_CHK:
            begin
                // reach an unseen neighbor over a nonzero residual
                if (!seen_reg[to_reg] && mem_rdata != '0)
                begin
                    seen_next[to_reg] = 1'b1;
                    par_we            = 1'b1;
                    par_waddr         = to_reg;
                    par_wdata         = from_reg;
                    if (tail_reg < CNT_W'(NODE_COUNT))
                    begin
                        q_we      = 1'b1;
                        q_waddr   = tail_reg[NODE_W-1:0];
                        q_wdata   = to_reg;
                        tail_next = tail_reg + 1'b1;
                    end
                end
                if (to_reg == NODE_W'(NODE_COUNT - 1))
                begin
                    state_next = ST_BFS_POP;
                end
                else
                begin
                    to_next    = to_reg + 1'b1;
                    state_next = ST_BFS_RD;
                end
            end
            ST_TR_PAR:
            begin
                if (node_reg == src_node || steps_reg == CNT_W'(NODE_COUNT))
                begin
                    node_next  = dst_node;
                    steps_next = '0;
                    state_next = ST_UP_PAR;
                end
                else
                begin
                    state_next = ST_TR_PWAIT;
                end
            end
            ST_TR_PWAIT:
            begin
                prev_next  = par_rdata;
                mem_raddr  = cell_addr(par_rdata, node_reg);
                state_next = ST_TR_CMP;
            end
            ST_TR_CMP:
            begin
                // bottleneck is the smallest residual on the path
                alu_op     = ALU_MIN;
                alu_a      = FLOW_W'(bott_reg);
                alu_b      = FLOW_W'(mem_rdata);
                bott_next  = alu_y[RES_W-1:0];
                node_next  = prev_reg;
                steps_next = steps_reg + 1'b1;
                state_next = ST_TR_PAR;
            end
            ST_UP_PAR:
            begin
                if (node_reg == src_node || steps_reg == CNT_W'(NODE_COUNT))
                begin
                    alu_op     = ALU_ADD;
                    alu_a      = flow_reg;
                    alu_b      = FLOW_W'(bott_reg);
                    flow_next  = alu_y;
                    state_next = ST_BFS_INIT;
                end
                else
                begin
                    state_next = ST_UP_PWAIT;
                end
            end
            ST_UP_PWAIT:
            begin
                prev_next  = par_rdata;
                mem_raddr  = cell_addr(par_rdata, node_reg);
                state_next = ST_UP_WF;
            end
            ST_UP_WF:
            begin
                // forward residual down, fetch the reverse one
                alu_op     = ALU_SUB;
                alu_a      = FLOW_W'(mem_rdata);
                alu_b      = FLOW_W'(bott_reg);
                mem_we     = 1'b1;
                mem_waddr  = cell_addr(prev_reg, node_reg);
                mem_wdata  = alu_y[RES_W-1:0];
                mem_raddr  = cell_addr(node_reg, prev_reg);
                state_next = ST_UP_WR;
            end
            ST_UP_WR:
            begin
                alu_op     = ALU_ADD;
                alu_a      = FLOW_W'(mem_rdata);
                alu_b      = FLOW_W'(bott_reg);
                mem_we     = 1'b1;
                mem_waddr  = cell_addr(node_reg, prev_reg);
                mem_wdata  = alu_y[RES_W-1:0];
                node_next  = prev_reg;
                steps_next = steps_reg + 1'b1;
                state_next = ST_UP_PAR;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    total_next     = flow_reg[OUT_W-1:0];
                    load_pos_next  = '0;
                    state_next     = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            load_pos_reg  <= '0;
            fill_reg      <= '0;
            flow_reg      <= '0;
            steps_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            seen_reg      <= '0;
            source_reg    <= CFG_W'(0);
            sink_reg      <= CFG_W'(7);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_pos_reg  <= load_pos_next;
            fill_reg      <= fill_next;
            flow_reg      <= flow_next;
            steps_reg     <= steps_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            seen_reg      <= seen_next;
            source_reg    <= source_next;
            sink_reg      <= sink_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        bott_reg  <= bott_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
        node_reg  <= node_next;
        prev_reg  <= prev_next;
        total_reg <= total_next;
    end

    // a request marked last always starts a computation
    `MFBA_ASSERT(a_last_stalls, (in_valid && in_ready && last_entry) |=> !in_ready, "last request did not start computation")
    // an augmenting path never carries a zero bottleneck
    `MFBA_ASSERT(a_bott_nonzero, (state_reg == ST_UP_WR) |-> (bott_reg != '0), "zero bottleneck on path")
    // the search queue never overruns
    `MFBA_ASSERT(a_tail_bound, int'(tail_reg) <= NODE_COUNT, "queue tail beyond node count")
    // dequeue never passes enqueue
    `MFBA_ASSERT(a_head_tail, head_reg <= tail_reg, "queue head passed tail")

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// self-checking testbench for the max flow block: loads capacity matrices, predicts the
// edmonds-karp total flow and checks every result through the valid/ready channels
// depends on mfba_pkg and max_flow_bfs_augment
`timescale 1ns / 100ps
`default_nettype none

module tb;
    import mfba_pkg::*;

    localparam int NODES = 8;
    localparam int CELLS = NODES * NODES;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [CAP_W-1:0] capacity = '0;
    logic last_entry = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [OUT_W-1:0] total_flow;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // predictor state
    logic [CFG_W-1:0] src_node;
    logic [CFG_W-1:0] dst_node;
    int unsigned resid [CELLS];
    int unsigned load_pos;
    logic [OUT_W-1:0] flow_queue [$];

    int errors = 0;
    int idle_in_pct = 0;
    int idle_out_pct = 0;
    int stall_count = 0;

    max_flow_bfs_augment #(.NODE_COUNT(NODES)) DUT (.*);

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // edmonds-karp on the predictor's residual copy
    function automatic int unsigned ek_flow(input int unsigned s, input int unsigned t);
        int unsigned par [NODES];
        bit seen [NODES];
        int unsigned q [NODES];
        int unsigned head, tail, from, node, prev, neck, sum;
        sum = 0;
        if (s == t) return 0;
        forever
        begin
            foreach (seen[i]) seen[i] = 1'b0;
            head = 0;
            tail = 0;
            q[tail++] = s;
            seen[s] = 1'b1;
            par[s] = s;
            while (head < tail)
            begin
                from = q[head++];
                for (int to = 0; to < NODES; to++)
                begin
                    if (!seen[to] && resid[from*NODES+to] > 0)
                    begin
                        seen[to] = 1'b1;
                        par[to] = from;
                        if (tail < NODES) q[tail++] = to;
                    end
                end
            end
            if (!seen[t]) break;
            neck = 32'hFFFF_FFFF;
            node = t;
            for (int k = 0; node != s && k < NODES; k++)
            begin
                prev = par[node];
                if (resid[prev*NODES+node] < neck) neck = resid[prev*NODES+node];
                node = prev;
            end
            node = t;
            for (int k = 0; node != s && k < NODES; k++)
            begin
                prev = par[node];
                resid[prev*NODES+node] -= neck;
                resid[node*NODES+prev] += neck;
                node = prev;
            end
            sum += neck;
        end
        return sum;
    endfunction

    // predictor step for one accepted request
    function automatic void predict_entry(input logic [CAP_W-1:0] cap, input logic last);
        if (load_pos < CELLS) resid[load_pos] = cap;
        load_pos++;
        if (last || load_pos >= CELLS)
        begin
            flow_queue.push_back(OUT_W'(ek_flow(src_node, dst_node)));
            foreach (resid[i]) resid[i] = 0;
            load_pos = 0;
        end
    endfunction

    // send one request with random sender idling; valid stays up for a follow-on request
    task automatic send_entry(input logic [CAP_W-1:0] cap, input logic last);
        if ($urandom_range(99) < idle_in_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_in_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        capacity <= cap;
        last_entry <= last;
        do @(posedge clk); while (!in_ready);
        predict_entry(cap, last);
    endtask

    // drop valid after the last request of a run
    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        idle_input();
        while (flow_queue.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_SOURCE) src_node = val;
        else if (idx == CFG_SINK) dst_node = val;
    endtask

    task automatic set_ends(input int s, input int t);
        wait_drained();
        write_reg(CFG_SOURCE, CFG_W'(s));
        write_reg(CFG_SINK, CFG_W'(t));
        cfg_valid <= 1'b0;
    endtask

    // random sparse-ish matrix, n entries, last marked
    task automatic send_matrix(input int n, input int density, input bit wide);
        logic [CAP_W-1:0] c;
        for (int i = 0; i < n; i++)
        begin
            c = ($urandom_range(99) < density) ?
                (wide ? CAP_W'($urandom) : CAP_W'($urandom_range(1, 20))) : '0;
            send_entry(c, i == n - 1);
        end
    endtask

    // result checker with random receiver stalls
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= idle_out_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (flow_queue.size() == 0)
                report_mismatch("unexpected result", total_flow, -1);
            else if (total_flow !== flow_queue[0])
                report_mismatch("total_flow", total_flow, flow_queue.pop_front());
            else
                void'(flow_queue.pop_front());
        end
    end

    // watchdog on cycles with no accepted transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count > WATCHDOG_LIMIT)
        begin
            $display("max_flow_bfs_augment test failed");
            $finish;
        end
    end

    task automatic test_directed();
        // full matrix of maximum capacity, default ends
        for (int i = 0; i < CELLS; i++) send_entry(16'hFFFF, 1'b0);
        // single edge source to sink, last marked early
        send_entry(16'd0, 1'b0);
        send_entry(16'd0, 1'b0);
        send_entry(16'd0, 1'b0);
        send_entry(16'd0, 1'b0);
        send_entry(16'd0, 1'b0);
        send_entry(16'd0, 1'b0);
        send_entry(16'd0, 1'b0);
        send_entry(16'h8001, 1'b1);
        // single-entry matrix
        send_entry(16'h7FFE, 1'b1);
        // source equals sink
        set_ends(3, 3);
        for (int i = 0; i < CELLS; i++) send_entry(16'hFFFF, 1'b0);
        set_ends(7, 0);
        send_matrix(CELLS, 60, 1'b1);
        set_ends(0, 7);
    endtask

    task automatic test_random(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(15) == 0)
                set_ends($urandom_range(7), $urandom_range(7));
            n = ($urandom_range(9) == 0) ? CELLS : $urandom_range(1, CELLS);
            send_matrix(n, $urandom_range(10, 90), $urandom_range(1));
            sent += n;
            // hold off until all flows are out
            if ($urandom_range(20) == 0)
            begin
                idle_input();
                while (flow_queue.size() != 0) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        src_node = 3'd0;
        dst_node = 3'd7;
        load_pos = 0;
        foreach (resid[i]) resid[i] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        idle_in_pct = 26;
        idle_out_pct = 77;
        test_random(450);
        idle_in_pct = 77;
        idle_out_pct = 26;
        test_random(450);
        idle_in_pct = 0;
        idle_out_pct = 0;
        test_random(500);
        set_ends(7, 7);
        wait_drained();
        if (errors == 0 && flow_queue.size() == 0)
            $display("max_flow_bfs_augment test passed");
        else
            $display("max_flow_bfs_augment test failed");
        $finish;
    end
endmodule

`default_nettype wire
